// ===== rtl/rsb_pkg.sv =====
// types, codes and backoff tables shared by the restart supervisor modules
package rsb_pkg;

  // event codes
  localparam logic [2:0] OpFailure     = 3'd0;
  localparam logic [2:0] OpSuccess     = 3'd1;
  localparam logic [2:0] OpTimeout     = 3'd2;
  localparam logic [2:0] OpUnavailable = 3'd3;
  localparam logic [2:0] OpReset       = 3'd4;

  // role status codes
  localparam logic [1:0] StatusReady    = 2'd0;
  localparam logic [1:0] StatusDegraded = 2'd1;
  localparam logic [1:0] StatusGivingUp = 2'd2;

  // configuration register indexes
  localparam logic RegThreshold = 1'b0;
  localparam logic RegBudget    = 1'b1;

  // register reset values
  localparam logic [7:0] ThresholdReset = 8'd3;
  localparam logic [7:0] BudgetReset    = 8'd5;

  localparam int unsigned JitW = 13;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  role_index;
    logic [31:0] random_draw;
  } in_t;

  typedef struct packed {
    logic        restart_requested;
    logic        abandoned;
    logic [7:0]  failure_count;
    logic [7:0]  attempt_count;
    logic [15:0] backoff_ms;
    logic [1:0]  role_status;
  } out_t;

  // one role's restart record
  typedef struct packed {
    logic [7:0]  failures;
    logic [7:0]  attempts;
    logic [15:0] delay;
    logic        gave_up;
    logic        ready_flag;
  } rec_t;

  localparam rec_t RecReset = '{
    failures: 8'd0, attempts: 8'd0, delay: 16'd0, gave_up: 1'b0, ready_flag: 1'b1
  };

  // stage enables from the sequencer to the update unit
  typedef struct packed {
    logic calc_en;
    logic mul_en;
  } ctl_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StMul,
    StDone
  } state_e;

  // backoff base for a clamped exponent, capped at 30000
  function automatic logic [15:0] base_ms(logic [2:0] e);
    logic [15:0] b;
    case (e)
      3'd0:    b = 16'd250;
      3'd1:    b = 16'd500;
      3'd2:    b = 16'd1000;
      3'd3:    b = 16'd2000;
      3'd4:    b = 16'd4000;
      3'd5:    b = 16'd8000;
      3'd6:    b = 16'd16000;
      default: b = 16'd30000;
    endcase
    return b;
  endfunction

  // jitter span: base / 5 plus one
  function automatic logic [JitW-1:0] span(logic [2:0] e);
    logic [JitW-1:0] s;
    case (e)
      3'd0:    s = 13'd51;
      3'd1:    s = 13'd101;
      3'd2:    s = 13'd201;
      3'd3:    s = 13'd401;
      3'd4:    s = 13'd801;
      3'd5:    s = 13'd1601;
      3'd6:    s = 13'd3201;
      default: s = 13'd6001;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/rsb_state_mem.sv =====
// per-role record memory with valid bits standing in for the reset values
module rsb_state_mem #(
  parameter int unsigned NUM_ROLES = 16,
  parameter int unsigned IdxW      = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output rsb_pkg::rec_t       rd_rec_o,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  rsb_pkg::rec_t       wr_rec_i
);

  rsb_pkg::rec_t          mem_q [NUM_ROLES];
  logic [NUM_ROLES-1:0]   vld_q;
  rsb_pkg::rec_t          rdata_q;
  logic                   rvld_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_rec_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_idx_i];
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_idx_i];
      end
    end
  end

  // never-written entries read as the reset record
  assign rd_rec_o = rvld_q ? rdata_q : rsb_pkg::RecReset;

endmodule

// ===== rtl/rsb_update.sv =====
// event decision and jittered backoff unit: decide stage, then multiply stage
module rsb_update (
  input  logic          clk_i,
  input  rsb_pkg::ctl_t ctl_i,
  input  logic [2:0]    op_i,
  input  logic [31:0]   draw_i,
  input  rsb_pkg::rec_t rec_i,
  input  logic [7:0]    threshold_i,
  input  logic [7:0]    budget_i,
  output rsb_pkg::rec_t rec_o,
  output logic          req_o,
  output logic          gu_o
);

  rsb_pkg::rec_t                  nrec;
  logic                           nreq;
  logic                           ngu;
  logic                           njit;
  logic [7:0]                     fcnt;
  logic [7:0]                     expo;
  logic [2:0]                     ecode;

  rsb_pkg::rec_t                  rec_q;
  logic                           req_q;
  logic                           gu_q;
  logic                           jit_en_q;
  logic [15:0]                    base_q;
  logic [rsb_pkg::JitW-1:0]       span_q;
  logic [31:0]                    draw_q;
  logic [rsb_pkg::JitW-1:0]       jit_q;
  logic [31+rsb_pkg::JitW:0]      prod;

  // event decision on the fetched record
  always_comb begin
    nrec = rec_i;
    nreq = 1'b0;
    ngu  = 1'b0;
    njit = 1'b0;
    fcnt = (rec_i.failures == 8'hff) ? 8'hff : rec_i.failures + 8'd1;
    case (op_i)
      rsb_pkg::OpFailure: begin
        nrec.failures   = fcnt;
        nrec.ready_flag = 1'b0;
        if (fcnt >= threshold_i) begin
          if (rec_i.attempts >= budget_i) begin
            nrec.gave_up = 1'b1;
            ngu          = 1'b1;
          end else begin
            nrec.attempts = rec_i.attempts + 8'd1;
            nreq          = 1'b1;
            njit          = 1'b1;
          end
        end
      end
      rsb_pkg::OpSuccess: begin
        nrec.failures   = 8'd0;
        nrec.gave_up    = 1'b0;
        nrec.ready_flag = 1'b1;
      end
      rsb_pkg::OpTimeout: begin
        nrec.failures   = 8'd0;
        nrec.ready_flag = 1'b1;
      end
      rsb_pkg::OpUnavailable: begin
        nrec.ready_flag = 1'b0;
      end
      rsb_pkg::OpReset: begin
        nrec.failures   = 8'd0;
        nrec.delay      = 16'd0;
        nrec.gave_up    = 1'b0;
        nrec.ready_flag = 1'b1;
      end
      default: begin
        nrec = rec_i;
      end
    endcase
    if (op_i != rsb_pkg::OpFailure) begin
      ngu = nrec.gave_up;
    end
  end

  // clamped backoff exponent: attempts after the increment, minus one
  assign expo  = rec_i.attempts;
  assign ecode = (expo >= 8'd7) ? 3'd7 : expo[2:0];

  // decide stage registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.calc_en) begin
      rec_q    <= nrec;
      req_q    <= nreq;
      gu_q     <= ngu;
      jit_en_q <= njit;
      base_q   <= rsb_pkg::base_ms(ecode);
      span_q   <= rsb_pkg::span(ecode);
      draw_q   <= draw_i;
    end
  end

  // multiply-shift jitter
  assign prod = (32 + rsb_pkg::JitW)'(draw_q) * (32 + rsb_pkg::JitW)'(span_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      jit_q <= prod[31+rsb_pkg::JitW:32];
    end
  end

  // final record
  always_comb begin
    rec_o = rec_q;
    if (jit_en_q) begin
      rec_o.delay = base_q + 16'(jit_q);
    end
  end

  assign req_o = req_q;
  assign gu_o  = gu_q;

endmodule

// ===== rtl/restart_supervisor_backoff.sv =====
// restart supervisor top level: config registers, sequencer, result register
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------
//  in       | in        | in_valid_i/in_ready_o | rsb_pkg::in_t
//  out      | out       | out_valid_o/out_ready_i | rsb_pkg::out_t
//  config   | in        | APB psel/penable      | threshold, budget
//
// one event at a time: accept and record fetch, decide, jitter multiply, write
// back; the sequenced record read-modify-write takes no new event before write back.
// the result is loaded into the output register at write back.
// reset marks every role record as unwritten; the first read returns the
// reset record, so no clearing pass is needed.
// a stalled result holds the write-back stage; a new request is taken while
// an earlier result still waits on the output.
module restart_supervisor_backoff #(
  parameter int unsigned NUM_ROLES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsb_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned IdxW = (NUM_ROLES > 1) ? $clog2(NUM_ROLES) : 1;

  rsb_pkg::state_e state_q, state_d;
  logic [7:0]      threshold_q;
  logic [7:0]      budget_q;
  rsb_pkg::in_t    in_q;
  logic            oor_q;
  logic            out_valid_q;
  rsb_pkg::out_t   out_q;

  logic            accept;
  logic            slot_free;
  logic            finish;
  rsb_pkg::ctl_t   ctl;
  logic            in_oor;
  rsb_pkg::rec_t   rd_rec;
  rsb_pkg::rec_t   new_rec;
  logic            upd_req;
  logic            upd_gu;
  logic            cfg_wr;
  rsb_pkg::out_t   res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= rsb_pkg::ThresholdReset;
      budget_q    <= rsb_pkg::BudgetReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        rsb_pkg::RegThreshold: threshold_q <= pwdata[7:0];
        rsb_pkg::RegBudget:    budget_q    <= pwdata[7:0];
        default:               threshold_q <= threshold_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rsb_pkg::RegThreshold: prdata = {24'd0, threshold_q};
      rsb_pkg::RegBudget:    prdata = {24'd0, budget_q};
      default:               prdata = 32'd0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsb_pkg::StIdle: if (in_valid_i) state_d = rsb_pkg::StRead;
      rsb_pkg::StRead: state_d = rsb_pkg::StMul;
      rsb_pkg::StMul:  state_d = rsb_pkg::StDone;
      rsb_pkg::StDone: if (slot_free) state_d = rsb_pkg::StIdle;
      default:         state_d = rsb_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    ctl.calc_en = 1'b0;
    ctl.mul_en  = 1'b0;
    finish      = 1'b0;
    case (state_q)
      rsb_pkg::StIdle: in_ready_o  = 1'b1;
      rsb_pkg::StRead: ctl.calc_en = 1'b1;
      rsb_pkg::StMul:  ctl.mul_en  = 1'b1;
      rsb_pkg::StDone: finish      = slot_free;
      default:         in_ready_o  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_oor    = {5'd0, in_data_i.role_index} >= 9'(NUM_ROLES);

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q  <= in_data_i;
      oor_q <= in_oor;
    end
  end

  rsb_state_mem #(
    .NUM_ROLES (NUM_ROLES),
    .IdxW      (IdxW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_idx_i (IdxW'(in_data_i.role_index)),
    .rd_rec_o (rd_rec),
    .wr_en_i  (finish && !oor_q),
    .wr_idx_i (IdxW'(in_q.role_index)),
    .wr_rec_i (new_rec)
  );

  rsb_update u_update (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .op_i        (in_q.op),
    .draw_i      (in_q.random_draw),
    .rec_i       (rd_rec),
    .threshold_i (threshold_q),
    .budget_i    (budget_q),
    .rec_o       (new_rec),
    .req_o       (upd_req),
    .gu_o        (upd_gu)
  );

  // result assembly; roles out of range report all zero
  always_comb begin
    res = '0;
    if (!oor_q) begin
      res.restart_requested = upd_req;
      res.abandoned         = upd_gu;
      res.failure_count     = new_rec.failures;
      res.attempt_count     = new_rec.attempts;
      res.backoff_ms        = new_rec.delay;
      if (new_rec.gave_up) begin
        res.role_status = rsb_pkg::StatusGivingUp;
      end else if (new_rec.ready_flag) begin
        res.role_status = rsb_pkg::StatusReady;
      end else begin
        res.role_status = rsb_pkg::StatusDegraded;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
